### rtl/m68kdec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m68kdec_pkg
// Types, codes and helpers shared by the 68000 opcode decoder.
// ----------------------------------------------------------------------------
package m68kdec_pkg;

  // Opcode lines (top four bits of the opword)
  localparam logic [3:0] LINE_IMM    = 4'h0;
  localparam logic [3:0] LINE_MOVE_B = 4'h1;
  localparam logic [3:0] LINE_MOVE_L = 4'h2;
  localparam logic [3:0] LINE_MOVE_W = 4'h3;
  localparam logic [3:0] LINE_MISC   = 4'h4;
  localparam logic [3:0] LINE_QUICK  = 4'h5;
  localparam logic [3:0] LINE_BRANCH = 4'h6;
  localparam logic [3:0] LINE_MOVEQ  = 4'h7;
  localparam logic [3:0] LINE_OR     = 4'h8;
  localparam logic [3:0] LINE_SUB    = 4'h9;
  localparam logic [3:0] LINE_CMP    = 4'hB;
  localparam logic [3:0] LINE_AND    = 4'hC;
  localparam logic [3:0] LINE_ADD    = 4'hD;
  localparam logic [3:0] LINE_SHIFT  = 4'hE;

  // Decode outcomes
  localparam logic [3:0] OUT_ILLEGAL = 4'd0;
  localparam logic [3:0] OUT_FIELDS  = 4'd1;
  localparam logic [3:0] OUT_LINE4   = 4'd2;
  localparam logic [3:0] OUT_MOVES   = 4'd3;
  localparam logic [3:0] OUT_MOVE_B  = 4'd4;
  localparam logic [3:0] OUT_MOVE_L  = 4'd5;
  localparam logic [3:0] OUT_MOVE_W  = 4'd6;
  localparam logic [3:0] OUT_MOVEQ   = 4'd7;
  localparam logic [3:0] OUT_EXG     = 4'd8;

  // Operation ids
  localparam logic [5:0] OP_NOP      = 6'd0;
  localparam logic [5:0] OP_ORI_CCR  = 6'd4;
  localparam logic [5:0] OP_OR       = 6'd10;
  localparam logic [5:0] OP_AND      = 6'd11;
  localparam logic [5:0] OP_SUB      = 6'd12;
  localparam logic [5:0] OP_ADD      = 6'd13;
  localparam logic [5:0] OP_EOR      = 6'd14;
  localparam logic [5:0] OP_MOVEP_TO = 6'd15;
  localparam logic [5:0] OP_MOVEP_FR = 6'd16;
  localparam logic [5:0] OP_DBCC     = 6'd17;
  localparam logic [5:0] OP_BRA      = 6'd18;
  localparam logic [5:0] OP_BSR      = 6'd19;
  localparam logic [5:0] OP_BCC      = 6'd20;
  localparam logic [5:0] OP_ABCD     = 6'd21;
  localparam logic [5:0] OP_SBCD     = 6'd22;
  localparam logic [5:0] OP_MULU     = 6'd23;
  localparam logic [5:0] OP_MULS     = 6'd24;
  localparam logic [5:0] OP_DIVU     = 6'd25;
  localparam logic [5:0] OP_DIVS     = 6'd26;
  localparam logic [5:0] OP_ASR      = 6'd27;

  // Operand fetch kinds
  localparam logic [4:0] FK_BIT_DYN    = 5'd1;
  localparam logic [4:0] FK_MOVEP      = 5'd2;
  localparam logic [4:0] FK_UWORD      = 5'd3;
  localparam logic [4:0] FK_IMM        = 5'd4;
  localparam logic [4:0] FK_ADDQ       = 5'd5;
  localparam logic [4:0] FK_DBCC       = 5'd6;
  localparam logic [4:0] FK_SCC        = 5'd7;
  localparam logic [4:0] FK_BR_SHORT   = 5'd8;
  localparam logic [4:0] FK_BRANCH     = 5'd9;
  localparam logic [4:0] FK_ADDX_DN    = 5'd10;
  localparam logic [4:0] FK_ADDX_PREDEC = 5'd11;
  localparam logic [4:0] FK_DIV        = 5'd12;
  localparam logic [4:0] FK_MATH       = 5'd13;
  localparam logic [4:0] FK_MATH_DN    = 5'd14;
  localparam logic [4:0] FK_ADDA       = 5'd15;
  localparam logic [4:0] FK_CMPA       = 5'd16;
  localparam logic [4:0] FK_CMPM       = 5'd17;
  localparam logic [4:0] FK_CMP        = 5'd18;
  localparam logic [4:0] FK_SHIFT_DN   = 5'd19;
  localparam logic [4:0] FK_SHIFT_MEM  = 5'd20;

  // Operand sizes
  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_WORD = 2'd1;
  localparam logic [1:0] SZ_LONG = 2'd2;

  // CPU levels
  localparam logic [1:0] CPU_010 = 2'd1;
  localparam logic [1:0] CPU_020 = 2'd2;

  // CCR update rules
  localparam logic [3:0] CCR_NONE  = 4'd0;
  localparam logic [3:0] CCR_BASIC = 4'd1;
  localparam logic [3:0] CCR_ADD   = 4'd2;
  localparam logic [3:0] CCR_SUB   = 4'd3;
  localparam logic [3:0] CCR_ADDX  = 4'd4;
  localparam logic [3:0] CCR_SUBX  = 4'd5;
  localparam logic [3:0] CCR_CMP   = 4'd6;
  localparam logic [3:0] CCR_DIV   = 4'd7;
  localparam logic [3:0] CCR_BTST  = 4'd8;

  // Immediate-group selectors (bits 11..9 of line 0)
  localparam logic [2:0] SEL_ORI  = 3'd0;
  localparam logic [2:0] SEL_ANDI = 3'd1;
  localparam logic [2:0] SEL_SUBI = 3'd2;
  localparam logic [2:0] SEL_ADDI = 3'd3;
  localparam logic [2:0] SEL_BAD4 = 3'd4;
  localparam logic [2:0] SEL_EORI = 3'd5;
  localparam logic [2:0] SEL_CMPI = 3'd6;
  localparam logic [2:0] SEL_BAD7 = 3'd7;

  // Effective-address modes
  localparam logic [2:0] EA_DREG = 3'd0;
  localparam logic [2:0] EA_AREG = 3'd1;
  localparam logic [2:0] EA_EXT  = 3'd7;

  typedef struct packed {
    logic       valid;
    logic       data;
    logic       alt;
    logic       data_alt;
    logic       mem_alt;
    logic       dst_alt;
  } ea_t;

  typedef struct packed {
    logic [3:0] outcome;
    logic [5:0] op;
    logic [4:0] fetch;
    logic [1:0] size;
    logic       rd;
    logic       wr;
    logic       sup;
    logic       stk;
    logic [1:0] cpu;
    logic       lanes;
    logic [3:0] rule;
    logic       zst;
  } dec_t;

  function automatic logic ea_valid(logic [2:0] m, logic [2:0] r);
    return (m != EA_EXT) || (r <= 3'd4);
  endfunction

  function automatic logic ea_alt(logic [2:0] m, logic [2:0] r);
    return (m != EA_EXT) || (r <= 3'd1);
  endfunction

  function automatic dec_t dec_fill(logic [5:0] op, logic [4:0] fetch, logic [1:0] size,
                                    logic rd, logic wr, logic [3:0] rule);
    dec_t d;
    d         = '0;
    d.outcome = OUT_FIELDS;
    d.op      = op;
    d.fetch   = fetch;
    d.size    = size;
    d.rd      = rd;
    d.wr      = wr;
    d.rule    = rule;
    d.zst     = (rule == CCR_ADDX) || (rule == CCR_SUBX);
    return d;
  endfunction

endpackage

### rtl/m68k_opcode_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m68k_opcode_decoder
// Three-stage decoder for the first word of a 68000-family instruction.
// ----------------------------------------------------------------------------
// Takes one opword per clock and returns its decoded form through three
// register stages: stage one classifies the effective-address fields,
// stage two decodes the line into operation, fetch kind, size and flags,
// stage three clears the fields of illegal, delegated and prebuilt outcomes
// and holds the result.
// Throughput is one opword per cycle; each stage stalls only when the stage
// after it is full and not draining, so back-pressure loses nothing.
// Lines A and F decode as illegal; line 4 is reported as delegated.
module m68k_opcode_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] opword_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  decode_outcome_o,
  output logic [5:0]  operation_id_o,
  output logic [4:0]  fetch_kind_o,
  output logic [1:0]  operand_size_o,
  output logic        reads_operand_o,
  output logic        writes_result_o,
  output logic        needs_supervisor_o,
  output logic        pushes_stack_o,
  output logic [1:0]  min_cpu_o,
  output logic        byte_lanes_o,
  output logic [3:0]  ccr_rule_o,
  output logic        ccr_z_sticky_o
);
  import m68kdec_pkg::*;

  // Stage handshakes
  logic s1_v_q, s2_v_q, s3_v_q;
  logic s1_rdy, s2_rdy, s3_rdy;

  assign s3_rdy     = !s3_v_q || out_ready_i;
  assign s2_rdy     = !s2_v_q || s3_rdy;
  assign s1_rdy     = !s1_v_q || s2_rdy;
  assign in_ready_o = s1_rdy;

  // Stage 1: address-mode classes
  logic [2:0]  in_m, in_r, in_m2, in_r2;
  ea_t         ea_d, ea_q;
  logic [15:0] w_q;

  assign in_m  = opword_i[5:3];
  assign in_r  = opword_i[2:0];
  assign in_m2 = opword_i[8:6];
  assign in_r2 = opword_i[11:9];

  always_comb begin
    ea_d.valid    = ea_valid(in_m, in_r);
    ea_d.data     = ea_valid(in_m, in_r) && (in_m != EA_AREG);
    ea_d.alt      = ea_alt(in_m, in_r);
    ea_d.data_alt = ea_alt(in_m, in_r) && (in_m != EA_AREG);
    ea_d.mem_alt  = ea_alt(in_m, in_r) && (in_m >= 3'd2);
    ea_d.dst_alt  = ea_alt(in_m2, in_r2);
  end

  // Stage 2: line decode
  logic [2:0] m, r, sel, imm_i;
  logic [1:0] sc;
  logic [5:0] br_op;
  logic       b8, is_c, add;
  dec_t       dec_d, dec_q;
  logic       ok_d, ok_q;

  assign m     = w_q[5:3];
  assign r     = w_q[2:0];
  assign sc    = w_q[7:6];
  assign sel   = w_q[11:9];
  assign imm_i = {w_q[11], w_q[9], w_q[6]};
  assign b8    = w_q[8];
  assign is_c  = w_q[14];
  assign add   = w_q[14];
  assign br_op = (w_q[11:8] == 4'h0) ? OP_BRA :
                 (w_q[11:8] == 4'h1) ? OP_BSR : OP_BCC;

  always_comb begin
    dec_d = '0;
    ok_d  = 1'b1;
    unique case (w_q[15:12])
      LINE_IMM: begin
        if ((w_q & 16'hf138) == 16'h0108) begin
          dec_d = dec_fill(w_q[7] ? OP_MOVEP_TO : OP_MOVEP_FR, FK_MOVEP,
                           {1'b0, 1'b1} + {1'b0, w_q[6]}, 1'b0, 1'b0, CCR_NONE);
          dec_d.lanes = 1'b1;
        end else if (b8 || (w_q[15:8] == 8'h08)) begin
          if (sc != 2'd0 && !ea_q.alt) ok_d = 1'b0;
          dec_d = dec_fill({4'd0, sc}, {4'd0, b8}, (m == EA_DREG) ? SZ_LONG : SZ_BYTE,
                           1'b1, sc != 2'd0, CCR_BTST);
        end else if ((w_q & 16'h05bf) == 16'h003c) begin
          if (imm_i == 3'd4 || imm_i == 3'd5) ok_d = 1'b0;
          dec_d = dec_fill(imm_i[2] ? OP_ORI_CCR + {3'd0, imm_i} - 6'd2
                                    : OP_ORI_CCR + {3'd0, imm_i},
                           FK_UWORD, {1'b0, w_q[6]}, 1'b0, 1'b0, CCR_NONE);
          dec_d.sup = w_q[6];
        end else if (sc == 2'd3) begin
          ok_d = 1'b0;
        end else if (w_q[15:8] == 8'h0e) begin
          if (!ea_q.mem_alt) ok_d = 1'b0;
          dec_d.outcome = OUT_MOVES;
        end else begin
          if (!ea_q.data || (sel != SEL_CMPI && !ea_q.alt)) ok_d = 1'b0;
          if (sel == SEL_BAD4 || sel == SEL_BAD7) ok_d = 1'b0;
          case (sel)
            SEL_CMPI: begin
              if (m == EA_EXT && r[1]) begin
                dec_d = dec_fill(OP_NOP, FK_IMM, sc, 1'b1, 1'b1, CCR_NONE);
                dec_d.cpu = CPU_010;
              end else begin
                dec_d = dec_fill(OP_NOP, FK_IMM, sc, 1'b1, 1'b0, CCR_SUB);
              end
            end
            SEL_SUBI: dec_d = dec_fill(OP_SUB, FK_IMM, sc, 1'b1, 1'b1, CCR_SUB);
            SEL_ADDI: dec_d = dec_fill(OP_ADD, FK_IMM, sc, 1'b1, 1'b1, CCR_ADD);
            SEL_ORI:  dec_d = dec_fill(OP_OR, FK_IMM, sc, 1'b1, 1'b1, CCR_BASIC);
            SEL_ANDI: dec_d = dec_fill(OP_AND, FK_IMM, sc, 1'b1, 1'b1, CCR_BASIC);
            SEL_EORI: dec_d = dec_fill(OP_EOR, FK_IMM, sc, 1'b1, 1'b1, CCR_BASIC);
            default:  dec_d = '0;
          endcase
        end
      end
      LINE_MOVE_B, LINE_MOVE_L, LINE_MOVE_W: begin
        if (!ea_q.valid || !ea_q.dst_alt) ok_d = 1'b0;
        if (w_q[15:12] == LINE_MOVE_B && (m == EA_AREG || w_q[8:6] == EA_AREG)) ok_d = 1'b0;
        dec_d.outcome = (w_q[15:12] == LINE_MOVE_B) ? OUT_MOVE_B :
                        (w_q[15:12] == LINE_MOVE_L) ? OUT_MOVE_L : OUT_MOVE_W;
      end
      LINE_MISC: dec_d.outcome = OUT_LINE4;
      LINE_QUICK: begin
        if (sc != 2'd3) begin
          if (!ea_q.alt || (m == EA_AREG && sc == 2'd0)) ok_d = 1'b0;
          dec_d = b8 ? dec_fill(OP_SUB, FK_ADDQ, sc, 1'b1, 1'b1, CCR_SUB)
                     : dec_fill(OP_ADD, FK_ADDQ, sc, 1'b1, 1'b1, CCR_ADD);
        end else if (m == EA_AREG) begin
          dec_d = dec_fill(OP_DBCC, FK_DBCC, SZ_WORD, 1'b0, 1'b0, CCR_NONE);
        end else if (ea_q.data_alt) begin
          dec_d = dec_fill(OP_NOP, FK_SCC, SZ_BYTE, 1'b0, 1'b1, CCR_NONE);
        end else begin
          ok_d = 1'b0;
        end
      end
      LINE_BRANCH: begin
        if (w_q[7:0] == 8'h00) begin
          dec_d = dec_fill(br_op, FK_BRANCH, SZ_WORD, 1'b0, 1'b0, CCR_NONE);
        end else if (w_q[7:0] == 8'hff) begin
          dec_d = dec_fill(br_op, FK_BRANCH, SZ_LONG, 1'b0, 1'b0, CCR_NONE);
          dec_d.cpu = CPU_020;
        end else begin
          dec_d = dec_fill(br_op, FK_BR_SHORT, SZ_BYTE, 1'b0, 1'b0, CCR_NONE);
        end
        if (w_q[11:8] == 4'h1) begin
          dec_d.cpu = 2'd0;
          dec_d.stk = 1'b1;
        end
      end
      LINE_MOVEQ: begin
        if (b8) ok_d = 1'b0;
        dec_d.outcome = OUT_MOVEQ;
      end
      LINE_OR, LINE_AND: begin
        if (sc == 2'd0 && b8 && m <= EA_AREG) begin
          dec_d = dec_fill(is_c ? OP_ABCD : OP_SBCD,
                           (m == EA_DREG) ? FK_ADDX_DN : FK_ADDX_PREDEC,
                           SZ_BYTE, 1'b1, 1'b1, is_c ? CCR_ADDX : CCR_SUBX);
        end else if (sc == 2'd3 && ea_q.data) begin
          if (is_c) dec_d = dec_fill(b8 ? OP_MULS : OP_MULU, FK_MATH_DN, SZ_WORD,
                                     1'b1, 1'b1, CCR_BASIC);
          else      dec_d = dec_fill(b8 ? OP_DIVS : OP_DIVU, FK_DIV, SZ_WORD,
                                     1'b1, 1'b1, CCR_DIV);
        end else if (sc != 2'd3 && (b8 ? ea_q.mem_alt : ea_q.data)) begin
          dec_d = dec_fill(is_c ? OP_AND : OP_OR, b8 ? FK_MATH : FK_MATH_DN, sc,
                           1'b1, 1'b1, CCR_BASIC);
        end else if (is_c && b8 && (w_q[7:3] == 5'h08 || w_q[7:3] == 5'h09 ||
                                    w_q[7:3] == 5'h11)) begin
          dec_d.outcome = OUT_EXG;
        end else begin
          ok_d = 1'b0;
        end
      end
      LINE_SUB, LINE_ADD: begin
        if (sc == 2'd3) begin
          dec_d = dec_fill(add ? OP_ADD : OP_SUB, FK_ADDA, b8 ? SZ_LONG : SZ_WORD,
                           1'b1, 1'b1, add ? CCR_ADD : CCR_SUB);
        end else if (b8 ? ea_q.mem_alt : ((sc == 2'd0) ? ea_q.data : ea_q.valid)) begin
          dec_d = dec_fill(add ? OP_ADD : OP_SUB, b8 ? FK_MATH : FK_MATH_DN, sc,
                           1'b1, 1'b1, add ? CCR_ADD : CCR_SUB);
        end else if (m <= EA_AREG) begin
          dec_d = dec_fill(add ? OP_ADD : OP_SUB,
                           (m == EA_DREG) ? FK_ADDX_DN : FK_ADDX_PREDEC, sc,
                           1'b1, 1'b1, add ? CCR_ADDX : CCR_SUBX);
        end else begin
          ok_d = 1'b0;
        end
      end
      LINE_CMP: begin
        if (sc == 2'd3) begin
          if (!ea_q.valid) ok_d = 1'b0;
          dec_d = dec_fill(OP_NOP, FK_CMPA, b8 ? SZ_LONG : SZ_WORD, 1'b0, 1'b0, CCR_CMP);
        end else if (b8) begin
          if (m == EA_AREG)       dec_d = dec_fill(OP_NOP, FK_CMPM, sc, 1'b0, 1'b0, CCR_SUB);
          else if (ea_q.data_alt) dec_d = dec_fill(OP_EOR, FK_MATH, sc, 1'b1, 1'b1,
                                                   CCR_BASIC);
          else                    ok_d = 1'b0;
        end else begin
          if (!ea_q.valid) ok_d = 1'b0;
          dec_d = dec_fill(OP_NOP, FK_CMP, sc, 1'b0, 1'b0, CCR_SUB);
        end
      end
      LINE_SHIFT: begin
        if (sc != 2'd3) begin
          dec_d = dec_fill(OP_ASR + {3'd0, w_q[4:3], b8}, FK_SHIFT_DN, sc,
                           1'b1, 1'b1, CCR_NONE);
        end else begin
          if (w_q[11] || !ea_q.mem_alt) ok_d = 1'b0;
          dec_d = dec_fill(OP_ASR + {3'd0, w_q[10:8]}, FK_SHIFT_MEM, SZ_WORD,
                           1'b1, 1'b1, CCR_NONE);
        end
      end
      default: ok_d = 1'b0;
    endcase
  end

  // Stage 3: clear fields that only a by-fields outcome carries
  dec_t res_d, res_q;

  always_comb begin
    res_d = '0;
    if (ok_q) begin
      if (dec_q.outcome == OUT_FIELDS) res_d = dec_q;
      else                             res_d.outcome = dec_q.outcome;
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_q <= in_valid_i;
      if (s2_rdy) s2_v_q <= s1_v_q;
      if (s3_rdy) s3_v_q <= s2_v_q;
    end
  end

  // Payload: advance a stage only when the next one can take it
  always_ff @(posedge clk_i) begin
    if (s1_rdy && in_valid_i) begin
      w_q  <= opword_i;
      ea_q <= ea_d;
    end
    if (s2_rdy && s1_v_q) begin
      dec_q <= dec_d;
      ok_q  <= ok_d;
    end
    if (s3_rdy && s2_v_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = s3_v_q;
  assign decode_outcome_o   = res_q.outcome;
  assign operation_id_o     = res_q.op;
  assign fetch_kind_o       = res_q.fetch;
  assign operand_size_o     = res_q.size;
  assign reads_operand_o    = res_q.rd;
  assign writes_result_o    = res_q.wr;
  assign needs_supervisor_o = res_q.sup;
  assign pushes_stack_o     = res_q.stk;
  assign min_cpu_o          = res_q.cpu;
  assign byte_lanes_o       = res_q.lanes;
  assign ccr_rule_o         = res_q.rule;
  assign ccr_z_sticky_o     = res_q.zst;

endmodule
